/* hdl/fnrc_pkg.sv */
// shared types and constants for the float narrowing checksum block
package fnrc_pkg;

    localparam int unsigned RANK_A_MOD = 29;
    localparam int unsigned RANK_B_MOD = 31;
    localparam int unsigned WORD_BITS  = 32;

    typedef struct packed {
        logic [63:0] in_word;
        logic        restart;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_word;
        logic [31:0] sum_rot29;
        logic [31:0] sum_rot31;
    } out_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic        restart;
    } mid_item_t;

endpackage

/* hdl/fnrc_front.sv */
// front stage: narrows the input word in double mode (else passes its low 32 bits) and registers it
module fnrc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 input_double,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fnrc_pkg::in_item_t   in_item,
    output logic                 mid_valid,
    input  logic                 mid_ready,
    output fnrc_pkg::mid_item_t  mid_item
);

    logic                valid_reg;
    fnrc_pkg::mid_item_t item_reg;
    logic [31:0]         conv;

    logic        sgn;
    logic [10:0] e;
    logic [51:0] m;
    logic [52:0] sig;
    logic [5:0]  shift;
    logic [52:0] q;
    logic [52:0] rem;
    logic [63:0] half;
    logic [52:0] mask;
    logic [31:0] res;
    logic [31:0] rexp;
    logic        up;

    always_comb
    begin
        sgn   = in_item.in_word[63];
        e     = in_item.in_word[62:52];
        m     = in_item.in_word[51:0];
        sig   = (e == 11'd0) ? {1'b0, m} : {1'b1, m};
        shift = 6'd29;
        rexp  = 32'd0;
        if (e >= 11'd897)
        begin
            rexp = {10'd0, e - 11'd897, 11'd0} << 12;
        end
        else if (e <= 11'd863)
        begin
            shift = 6'd63;
        end
        else
        begin
            shift = 6'(11'd926 - ((e == 11'd0) ? 11'd1 : e));
        end
        q    = sig >> shift;
        mask = (53'd1 << shift) - 53'd1;
        rem  = sig & mask;
        half = 64'd1 << (shift - 6'd1);
        up   = ({11'd0, rem} > half) || (({11'd0, rem} == half) && q[0]);
        res  = rexp + q[31:0] + {31'd0, up};
        if (res >= 32'h7F80_0000)
        begin
            res = 32'h7F80_0000;
        end
        if (e == 11'h7FF)
        begin
            conv = (m == 52'd0) ? {sgn, 31'h7F80_0000}
                                : {sgn, 31'h7FC0_0000 | {8'd0, m[51:29]}};
        end
        else if (e >= 11'd1151)
        begin
            conv = {sgn, 31'h7F80_0000};
        end
        else
        begin
            conv = {sgn, res[30:0]};
        end
    end

    assign in_ready  = !valid_reg || mid_ready;
    assign mid_valid = valid_reg;
    assign mid_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.word    <= input_double ? conv : in_item.in_word[31:0];
            item_reg.restart <= in_item.restart;
        end
    end

endmodule

/* hdl/fnrc_fifo.sv */
// short queue between front and back
module fnrc_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  fnrc_pkg::mid_item_t  wr_item,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output fnrc_pkg::mid_item_t  rd_item
);

    fnrc_pkg::mid_item_t mem_reg [2];
    logic                wp_reg;
    logic                rp_reg;
    logic [1:0]          cnt_reg;
    logic                wr_en;
    logic                rd_en;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd_en)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_item;
        end
    end

endmodule

/* hdl/fnrc_back.sv */
// back stage: rotate-xor fold into two checksums and output register
module fnrc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mid_valid,
    output logic                 mid_ready,
    input  fnrc_pkg::mid_item_t  mid_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fnrc_pkg::out_item_t  out_item
);

    logic [4:0]          rank_a_reg;
    logic [4:0]          rank_b_reg;
    logic [31:0]         acc_a_reg;
    logic [31:0]         acc_b_reg;
    logic                valid_reg;
    fnrc_pkg::out_item_t item_reg;
    logic [4:0]          ra;
    logic [4:0]          rb;
    logic [31:0]         aa;
    logic [31:0]         ab;
    logic [31:0]         acc_a_next;
    logic [31:0]         acc_b_next;
    logic [4:0]          rank_a_next;
    logic [4:0]          rank_b_next;
    logic                take;

    function automatic logic [31:0] rotl(input logic [31:0] w, input logic [4:0] r);
        logic [63:0] d;
        d = {w, w} << r;
        return d[63:32];
    endfunction

    assign mid_ready = !valid_reg || out_ready;
    assign take      = mid_valid && mid_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        ra = mid_item.restart ? 5'd0 : rank_a_reg;
        rb = mid_item.restart ? 5'd0 : rank_b_reg;
        aa = mid_item.restart ? 32'd0 : acc_a_reg;
        ab = mid_item.restart ? 32'd0 : acc_b_reg;
        acc_a_next  = aa ^ rotl(mid_item.word, ra);
        acc_b_next  = ab ^ rotl(mid_item.word, rb);
        rank_a_next = (ra == 5'(fnrc_pkg::RANK_A_MOD - 1)) ? 5'd0 : ra + 5'd1;
        rank_b_next = (rb == 5'(fnrc_pkg::RANK_B_MOD - 1)) ? 5'd0 : rb + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_a_reg <= 5'd0;
            rank_b_reg <= 5'd0;
            acc_a_reg  <= 32'd0;
            acc_b_reg  <= 32'd0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (mid_ready)
            begin
                valid_reg <= mid_valid;
            end
            if (take)
            begin
                rank_a_reg <= rank_a_next;
                rank_b_reg <= rank_b_next;
                acc_a_reg  <= acc_a_next;
                acc_b_reg  <= acc_b_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.out_word  <= mid_item.word;
            item_reg.sum_rot29 <= acc_a_next;
            item_reg.sum_rot31 <= acc_b_next;
        end
    end

endmodule

/* hdl/float_narrowing_rotxor_checksum.sv */
// top level: float narrowing with two rotate-xor checksums
// Input channel: push/full with in_data (word and restart flag); an item
// transfers when push is high and full is low.
// Output channel: empty/pop with out_data (converted word and both sums);
// the oldest result is shown while empty is low and transfers on pop.
// cfg_we/cfg_data write input_double (1 = double input, 0 = single).
// An input transfer passes the front register, then the two-entry queue,
// then the back register before its result is shown.
// Throughput: one item per cycle while pop keeps up; the front narrowing
// stage and the back fold each take a new word as their register empties.
// Reset clears the mode, ranks, sums and all queue state; the block then
// shows empty and not full.
// When pop stays low, results back up into the queue and the front
// register, then full rises; nothing is lost.
module float_narrowing_rotxor_checksum
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  fnrc_pkg::in_item_t   in_data,
    output logic                 empty,
    input  logic                 pop,
    output fnrc_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic                 cfg_data
);

    logic                input_double_reg;
    logic                in_ready;
    logic                f_valid;
    logic                f_ready;
    fnrc_pkg::mid_item_t f_item;
    logic                q_valid;
    logic                q_ready;
    fnrc_pkg::mid_item_t q_item;
    logic                out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_double_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            input_double_reg <= cfg_data;
        end
    end

    fnrc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .input_double (input_double_reg),
        .in_valid     (push),
        .in_ready     (in_ready),
        .in_item      (in_data),
        .mid_valid    (f_valid),
        .mid_ready    (f_ready),
        .mid_item     (f_item)
    );

    fnrc_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    fnrc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (q_valid),
        .mid_ready (q_ready),
        .mid_item  (q_item),
        .out_valid (out_valid),
        .out_ready (pop),
        .out_item  (out_data)
    );

    assign full  = !in_ready;
    assign empty = !out_valid;

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_data)))
        else $error("result changed while stalled");

    a_mode_single : assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !input_double_reg && in_ready) |=>
        (f_item.word == $past(in_data.in_word[31:0])))
        else $error("single mode word not passed through");

    a_full : assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (f_valid && !f_ready))
        else $error("full without back pressure");

endmodule

/* tb/tb_float_narrowing_rotxor_checksum.sv */
// testbench for the float narrowing checksum block: random and directed words, scoreboard check
class checksum_board;
    bit          dbl_mode;
    logic [4:0]  rk_a;
    logic [4:0]  rk_b;
    logic [31:0] sum_a;
    logic [31:0] sum_b;
    fnrc_pkg::out_item_t pending[$];
    int          errors;

    function new();
        dbl_mode = 0;
        rk_a = 0;
        rk_b = 0;
        sum_a = 0;
        sum_b = 0;
        errors = 0;
    endfunction

    function automatic logic [31:0] rot_left(logic [31:0] w, logic [4:0] r);
        if (r == 0)
            return w;
        return (w << r) | (w >> (6'd32 - r));
    endfunction

    function automatic logic [31:0] narrow(logic [63:0] d);
        logic [31:0] sgn;
        logic [31:0] e;
        logic [63:0] m;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] sh;
        logic [31:0] res;
        sgn = {d[63], 31'd0};
        e = {21'd0, d[62:52]};
        m = {12'd0, d[51:0]};
        if (e == 32'h7ff)
        begin
            if (m == 0)
                return sgn | 32'h7f800000;
            return sgn | 32'h7fc00000 | 32'(m >> 29);
        end
        if (e >= 1151)
            return sgn | 32'h7f800000;
        if (e == 0)
        begin
            sig = m;
            e = 1;
        end
        else
            sig = m | (64'd1 << 52);
        if (e >= 897)
            sh = 29;
        else
        begin
            sh = 926 - e;
            if (sh > 63)
                sh = 63;
        end
        q = sig >> sh;
        rem = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 1;
        if (e >= 897)
            res = ((e - 897) << 23) + 32'(q);
        else
            res = 32'(q);
        if (res >= 32'h7f800000)
            res = 32'h7f800000;
        return sgn | res;
    endfunction

    function void note_input(fnrc_pkg::in_item_t it);
        fnrc_pkg::out_item_t r;
        logic [31:0] w;
        if (it.restart)
        begin
            rk_a = 0;
            rk_b = 0;
            sum_a = 0;
            sum_b = 0;
        end
        w = dbl_mode ? narrow(it.in_word) : it.in_word[31:0];
        sum_a ^= rot_left(w, rk_a);
        sum_b ^= rot_left(w, rk_b);
        rk_a = (rk_a == 28) ? 5'd0 : rk_a + 5'd1;
        rk_b = (rk_b == 30) ? 5'd0 : rk_b + 5'd1;
        r.out_word = w;
        r.sum_rot29 = sum_a;
        r.sum_rot31 = sum_b;
        pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task check_result(fnrc_pkg::out_item_t got);
        fnrc_pkg::out_item_t want;
        if (pending.size() == 0)
        begin
            report("unexpected out_word", got.out_word, 32'd0);
            return;
        end
        want = pending.pop_front();
        if (got.out_word !== want.out_word)
            report("out_word", got.out_word, want.out_word);
        if (got.sum_rot29 !== want.sum_rot29)
            report("sum_rot29", got.sum_rot29, want.sum_rot29);
        if (got.sum_rot31 !== want.sum_rot31)
            report("sum_rot31", got.sum_rot31, want.sum_rot31);
    endtask
endclass

module tb_float_narrowing_rotxor_checksum;
    logic clk;
    logic rst_n;
    logic push;
    logic full;
    fnrc_pkg::in_item_t in_data;
    logic empty;
    logic pop;
    fnrc_pkg::out_item_t out_data;
    logic cfg_we;
    logic cfg_data;
    checksum_board board;
    int cycles;
    bit calm;

    float_narrowing_rotxor_checksum i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .in_data(in_data),
        .empty(empty),
        .pop(pop),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 200000)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // result side: random pop (held high while calm), check on each transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                board.check_result(out_data);
            pop <= calm ? 1'b1 : ($urandom_range(99) >= 11);
        end
    end

    task automatic send(logic [63:0] w, logic rs);
        fnrc_pkg::in_item_t it;
        it.in_word = w;
        it.restart = rs;
        while (!calm && $urandom_range(99) < 11)
        begin
            push <= 0;
            @(posedge clk);
        end
        push <= 1;
        in_data <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_input(it);
    endtask

    task automatic set_mode(bit m);
        push <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_we <= 1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 0;
        board.dbl_mode = m;
    endtask

    function automatic logic [63:0] rand_double();
        logic [63:0] d;
        d = {$urandom, $urandom};
        case ($urandom_range(7))
            0: d[62:52] = 11'h7ff;
            1: d[62:52] = 0;
            2: d[62:52] = 11'(874 + $urandom_range(24));
            3: d[62:52] = 11'(1150 + $urandom_range(1));
            4: d[28:0] = 29'h10000000;
            default: d[62:52] = 11'(860 + $urandom_range(300));
        endcase
        return d;
    endfunction

    initial
    begin
        board = new();
        rst_n = 0;
        push = 0;
        pop = 0;
        cfg_we = 0;
        cfg_data = 0;
        in_data = '0;
        calm = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send(64'hffffffff_00000000, 0);
        send(64'h00000000_ffffffff, 0);
        send(64'h12345678_80000001, 1);
        send(64'hffffffff_ffffffff, 0);
        set_mode(1);
        send(64'h7ff00000_00000000, 0);
        send(64'hfff00000_00000000, 0);
        send(64'h7ff00000_00000001, 0);
        send(64'hfff7ffff_ffffffff, 0);
        send(64'h000fffff_ffffffff, 0);
        send(64'h80000000_00000001, 0);
        send(64'h47efffff_f0000000, 0);
        send(64'h47efffff_e0000000, 0);
        send(64'h47f00000_00000000, 0);
        send(64'h3ff00000_10000000, 1);
        send(64'h3ff00000_30000000, 0);
        send(64'h36a00000_00000000, 0);
        send(64'h36a00000_00000001, 0);
        send(64'h38100000_00000000, 0);
        send(64'h380fffff_ffffffff, 0);
        send(64'h0000000_000000000, 0);
        for (int i = 0; i < 550; i++)
        begin
            calm = (i >= 200 && i < 300);
            if (i == 150 || i == 350)
                set_mode(0);
            if (i == 250 || i == 450)
                set_mode(1);
            if (board.dbl_mode)
                send(rand_double(), $urandom_range(19) == 0);
            else
                send({$urandom, $urandom}, $urandom_range(19) == 0);
        end
        push <= 0;
        calm = 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
